// File: rtl/bezier_envelope_compressor_macros.svh
// assertion macros shared by the compressor modules
`ifndef BEZIER_ENVELOPE_COMPRESSOR_MACROS_SVH
`define BEZIER_ENVELOPE_COMPRESSOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define BEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bec_pkg.sv
// shared widths, constants, register indexes and helpers of the compressor
package bec_pkg;

  localparam int SMP_W   = 24;
  localparam int GAIN_W  = 24;
  localparam int RATE_W  = 25;
  localparam int HOLD_W  = 40;
  localparam int ACC_W   = 48;
  localparam int PH_W    = 26;
  localparam int PEAK_W  = 28;
  localparam int AMP_W   = 28;
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 50;
  localparam int IDX_W   = 3;
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [RATE_W-1:0] ONE_Q24    = 25'd16777216;
  localparam logic [RATE_W-1:0] RATE_MIN   = 25'd1678;
  localparam logic [HOLD_W-1:0] GATE_FLOOR = 40'd17;
  localparam logic [ACC_W-1:0]  MASK48     = {ACC_W{1'b1}};

  localparam logic [IDX_W-1:0] CFG_THRESH    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_FAST      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SLOW      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_GATE_LVL  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_GATE_HOLD = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } bec_div_stat_t;

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
    logic [RATE_W-1:0] v;
    begin
      v = r;
      if (r < RATE_MIN) v = RATE_MIN;
      else if (r > ONE_Q24) v = ONE_Q24;
      return v;
    end
  endfunction

endpackage

// File: rtl/bec_mul.sv
// shared unsigned multiplier with registered product
module bec_mul (
  input  logic                           clk,
  input  logic [bec_pkg::MUL_A_W-1:0]    a,
  input  logic [bec_pkg::MUL_B_W-1:0]    b,
  output logic [bec_pkg::PROD_W-1:0]     prod
);
  import bec_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
  end

  assign prod = prod_r;

endmodule

// File: rtl/bec_div.sv
// bit-serial restoring divider: (dividend << 24) / divisor, saturated to 48 bits
module bec_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bec_pkg::ACC_W-1:0]    dividend,
  input  logic [23:0]                  divisor,
  output logic [bec_pkg::ACC_W-1:0]    quot,
  output bec_pkg::bec_div_stat_t       stat
);
  import bec_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [23:0]          rem_r, rem_nxt;
  logic [23:0]          div_r, div_nxt;
  logic [ACC_W-1:0]     dsr_r, dsr_nxt;
  logic [24:0]          rem2;
  logic [24:0]          diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    dsr_nxt  = dsr_r;
    rem2     = {rem_r, dsr_r[ACC_W-1]};
    diff     = rem2 - {1'b0, div_r};
    if (start) begin
      div_nxt = divisor;
      if (divisor == '0) begin
        dsr_nxt  = (dividend != '0) ? MASK48 : '0;
        done_nxt = 1'b1;
      end else if (dividend[ACC_W-1:24] >= divisor) begin
        // quotient would not fit in 48 bits
        dsr_nxt  = MASK48;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = dividend[ACC_W-1:24];
        dsr_nxt  = {dividend[23:0], 24'd0};
        busy_nxt = 1'b1;
        cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      end
    end else if (busy_r) begin
      if (rem2 >= {1'b0, div_r}) begin
        rem_nxt = diff[23:0];
        dsr_nxt = {dsr_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem2[23:0];
        dsr_nxt = {dsr_r[ACC_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      div_r  <= div_nxt;
      dsr_r  <= dsr_nxt;
    end
  end

  assign quot      = dsr_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`include "bezier_envelope_compressor_macros.svh"

  `BEC_ASSERT_NOW(a_rem_below_div, busy_r, rem_r < div_r, "divider remainder not below divisor")
  `BEC_ASSERT_NOW(a_no_restart, start, !busy_r, "divider started while busy")
  `BEC_ASSERT_NEXT(a_last_step, busy_r && cnt_r == '0, !busy_r && done_r, "divider did not finish")

endmodule

// File: rtl/bezier_envelope_compressor.sv
// compressor top: config registers, sequencer, shared multiplier and divider
//
// Mono compressor with gate, one 24-bit signed Q1.23 word at a time.
// Input channel: in_valid / in_stall / in_sample. A word is taken when
// in_valid is high and in_stall is low; in_stall stays high while a word
// is being worked on.
// Output channel: out_valid / out_stall / out_sample, one word per input.
// The result sits in an output register, so the next input is taken while
// a finished word still waits for the receiver; a stalled receiver holds
// only the final step until the register frees up.
// Threshold zero skips the reduction steps; a control phase wrap adds the
// history shift, and a wrap with the gate timer below one first runs the
// 48-step bit-serial divider, which ends early if the quotient saturates.
// All products go through one 28x25 multiplier, used up to 17 times per word.
// Config: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
// write only while idle. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) clears the history, accumulator, peak
// follower, sets phase to 1.0, gate timer to 2.0, and loads register defaults.
module bezier_envelope_compressor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [bec_pkg::SMP_W-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [bec_pkg::SMP_W-1:0] out_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bec_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bec_pkg::HOLD_W-1:0]    cfg_data
);
  import bec_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_AMP, S_PEAK, S_INT_M, S_INT, S_DIV_GO, S_DIV_WAIT, S_SHIFT,
    S_LM0, S_LM1, S_LM2, S_LM3, S_LM4, S_CBA, S_RED0, S_RED1, S_RED2,
    S_GAIN_M, S_GAIN
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0] thresh_r, thresh_nxt;
  logic [RATE_W-1:0] fast_r, fast_nxt;
  logic [RATE_W-1:0] slow_r, slow_nxt;
  logic [SMP_W-1:0]  gate_lvl_r, gate_lvl_nxt;
  logic [HOLD_W-1:0] gate_hold_r, gate_hold_nxt;

  logic [ACC_W-1:0]  hist_a_r, hist_a_nxt, hist_b_r, hist_b_nxt, hist_c_r, hist_c_nxt;
  logic [ACC_W-1:0]  accum_r, accum_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [PEAK_W-1:0] peak_r, peak_nxt;
  logic [HOLD_W-1:0] timer_r, timer_nxt;

  logic              neg_r, neg_nxt;
  logic [SMP_W-1:0]  mag_r, mag_nxt;
  logic [AMP_W-1:0]  amp_r, amp_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [1:0]        lsel_r, lsel_nxt;
  logic [ACC_W-1:0]  cb_r, cb_nxt, ba_r, ba_nxt, lerp_r, lerp_nxt, cba_r, cba_nxt;
  logic [RATE_W-1:0] gain_r, gain_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]  out_r, out_nxt;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic              div_start;
  logic [ACC_W-1:0]  div_quot;
  bec_div_stat_t     div_stat;

  logic [RATE_W-1:0] fr, sr, mr, u_w;
  logic [SMP_W:0]    mag_w;
  logic [ACC_W-1:0]  lx, ly, lval;
  logic [ACC_W:0]    amp_tmp;
  logic [PEAK_W:0]   ctrl_w;
  logic [PEAK_W-1:0] decayed_w;
  logic [SUM_W-1:0]  s_red;
  logic              red_sat;
  logic [RATE_W-1:0] red_w;
  logic [PROD_W:0]   res_tmp;
  logic [28:0]       res_w;

  bec_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (accum_r),
    .divisor  (timer_r[23:0]),
    .quot     (div_quot),
    .stat     (div_stat)
  );

  assign fr  = clamp_rate(fast_r);
  assign sr  = clamp_rate(slow_r);
  assign mr  = (fr < sr) ? fr : sr;
  assign u_w = ONE_Q24 - phase_r[RATE_W-1:0];

  always_comb begin
    case (lsel_r)
      2'd0: begin lx = hist_c_r; ly = hist_b_r; end
      2'd1: begin lx = hist_b_r; ly = hist_a_r; end
      default: begin lx = cb_r; ly = ba_r; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    thresh_nxt    = thresh_r;
    fast_nxt      = fast_r;
    slow_nxt      = slow_r;
    gate_lvl_nxt  = gate_lvl_r;
    gate_hold_nxt = gate_hold_r;
    hist_a_nxt    = hist_a_r;
    hist_b_nxt    = hist_b_r;
    hist_c_nxt    = hist_c_r;
    accum_nxt     = accum_r;
    phase_nxt     = phase_r;
    peak_nxt      = peak_r;
    timer_nxt     = timer_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    amp_nxt       = amp_r;
    sum_nxt       = sum_r;
    lsel_nxt      = lsel_r;
    cb_nxt        = cb_r;
    ba_nxt        = ba_r;
    lerp_nxt      = lerp_r;
    cba_nxt       = cba_r;
    gain_nxt      = gain_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    mag_w         = 25'h1000000 - {1'b0, in_sample};
    lval          = '0;
    amp_tmp       = '0;
    ctrl_w        = '0;
    decayed_w     = '0;
    s_red         = '0;
    red_sat       = 1'b0;
    red_w         = '0;
    res_tmp       = '0;
    res_w         = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESH:    thresh_nxt    = cfg_data[GAIN_W-1:0];
        CFG_FAST:      fast_nxt      = cfg_data[RATE_W-1:0];
        CFG_SLOW:      slow_nxt      = cfg_data[RATE_W-1:0];
        CFG_GATE_LVL:  gate_lvl_nxt  = cfg_data[SMP_W-1:0];
        CFG_GATE_HOLD: gate_hold_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_sample[SMP_W-1];
          mag_nxt   = in_sample[SMP_W-1] ? mag_w[SMP_W-1:0] : in_sample;
          state_nxt = S_AMP;
        end
      end
      S_AMP: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = {1'b0, thresh_r} + 25'd1048576;
        // gate hold timer
        if (mag_r > gate_lvl_r) timer_nxt = gate_hold_r;
        else if (timer_r >= HOLD_W'(mr) + GATE_FLOOR) timer_nxt = timer_r - HOLD_W'(mr);
        else timer_nxt = GATE_FLOOR;
        state_nxt = S_PEAK;
      end
      S_PEAK: begin
        amp_tmp = {1'b0, prod[47:0]} + 49'd524288;
        amp_nxt = (thresh_r != '0) ? amp_tmp[47:20] : AMP_W'(mag_r);
        ctrl_w  = {amp_nxt, 1'b0};
        decayed_w = (peak_r > PEAK_W'(sr)) ? (peak_r - PEAK_W'(sr)) : '0;
        // peak register keeps the low 28 bits
        peak_nxt  = ({1'b0, decayed_w} > ctrl_w) ? decayed_w : ctrl_w[PEAK_W-1:0];
        phase_nxt = phase_r + PH_W'(fr);
        state_nxt = S_INT_M;
      end
      S_INT_M: begin
        mul_a = peak_r;
        mul_b = fr;
        state_nxt = S_INT;
      end
      S_INT: begin
        accum_nxt = accum_r + ACC_W'(prod[PROD_W-1:24]);
        lsel_nxt  = 2'd0;
        if (phase_r > PH_W'(ONE_Q24)) begin
          state_nxt = (timer_r < HOLD_W'(ONE_Q24)) ? S_DIV_GO : S_SHIFT;
        end else begin
          state_nxt = S_LM0;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          accum_nxt = div_quot;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        phase_nxt  = phase_r - PH_W'(ONE_Q24);
        hist_c_nxt = hist_b_r;
        hist_b_nxt = hist_a_r;
        hist_a_nxt = accum_r;
        accum_nxt  = '0;
        state_nxt  = S_LM0;
      end
      // lerp: x*(1-t) + y*t, split in 24-bit halves
      S_LM0: begin
        mul_a = MUL_A_W'(lx[23:0]);
        mul_b = u_w;
        state_nxt = S_LM1;
      end
      S_LM1: begin
        sum_nxt = prod[SUM_W-1:0];
        mul_a = MUL_A_W'(ly[23:0]);
        mul_b = phase_r[RATE_W-1:0];
        state_nxt = S_LM2;
      end
      S_LM2: begin
        sum_nxt = (sum_r + prod[SUM_W-1:0]) >> 24;
        mul_a = MUL_A_W'(lx[ACC_W-1:24]);
        mul_b = u_w;
        state_nxt = S_LM3;
      end
      S_LM3: begin
        sum_nxt = sum_r + prod[SUM_W-1:0];
        mul_a = MUL_A_W'(ly[ACC_W-1:24]);
        mul_b = phase_r[RATE_W-1:0];
        state_nxt = S_LM4;
      end
      S_LM4: begin
        lval = sum_r[ACC_W-1:0] + prod[ACC_W-1:0];
        case (lsel_r)
          2'd0: cb_nxt = lval;
          2'd1: ba_nxt = lval;
          default: lerp_nxt = lval;
        endcase
        if (lsel_r == 2'd2) begin
          state_nxt = S_CBA;
        end else begin
          lsel_nxt  = lsel_r + 2'd1;
          state_nxt = S_LM0;
        end
      end
      S_CBA: begin
        cba_nxt   = ACC_W'(({1'b0, hist_b_r} + {1'b0, lerp_r}) >> 1);
        state_nxt = S_RED0;
      end
      S_RED0: begin
        mul_a = MUL_A_W'(cba_r[23:0]);
        mul_b = RATE_W'(thresh_r);
        if (thresh_r == '0) begin
          // no reduction: unit gain
          gain_nxt  = ONE_Q24;
          state_nxt = S_GAIN_M;
        end else begin
          state_nxt = S_RED1;
        end
      end
      S_RED1: begin
        sum_nxt = prod[SUM_W-1:0];
        mul_a = MUL_A_W'(cba_r[ACC_W-1:24]);
        mul_b = RATE_W'(thresh_r);
        state_nxt = S_RED2;
      end
      S_RED2: begin
        s_red   = sum_r + {6'd0, prod[19:0], 24'd0};
        red_sat = (prod[PROD_W-1:20] != '0) || (s_red[SUM_W-1:44] != '0);
        red_w   = red_sat ? ONE_Q24 : {1'b0, s_red[43:20]};
        gain_nxt  = ONE_Q24 - red_w;
        state_nxt = S_GAIN_M;
      end
      S_GAIN_M: begin
        mul_a = MUL_A_W'(amp_r);
        mul_b = gain_r;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        res_tmp = {1'b0, prod} + (PROD_W+1)'(24'h800000);
        res_w   = res_tmp[52:24];
        if (!out_valid_r || !out_stall) begin
          if (neg_r) begin
            if (res_w > 29'h800000) res_w = 29'h800000;
            out_nxt = SMP_W'(25'h1000000 - res_w[24:0]);
          end else begin
            if (res_w > 29'h7FFFFF) res_w = 29'h7FFFFF;
            out_nxt = res_w[SMP_W-1:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      thresh_r    <= '0;
      fast_r      <= 25'd1048576;
      slow_r      <= 25'd1048576;
      gate_lvl_r  <= '0;
      gate_hold_r <= 40'd268435456;
      hist_a_r    <= '0;
      hist_b_r    <= '0;
      hist_c_r    <= '0;
      accum_r     <= '0;
      phase_r     <= PH_W'(ONE_Q24);
      peak_r      <= '0;
      timer_r     <= HOLD_W'(ONE_Q24) << 1;
      lsel_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      thresh_r    <= thresh_nxt;
      fast_r      <= fast_nxt;
      slow_r      <= slow_nxt;
      gate_lvl_r  <= gate_lvl_nxt;
      gate_hold_r <= gate_hold_nxt;
      hist_a_r    <= hist_a_nxt;
      hist_b_r    <= hist_b_nxt;
      hist_c_r    <= hist_c_nxt;
      accum_r     <= accum_nxt;
      phase_r     <= phase_nxt;
      peak_r      <= peak_nxt;
      timer_r     <= timer_nxt;
      lsel_r      <= lsel_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      amp_r       <= amp_nxt;
      sum_r       <= sum_nxt;
      cb_r        <= cb_nxt;
      ba_r        <= ba_nxt;
      lerp_r      <= lerp_nxt;
      cba_r       <= cba_nxt;
      gain_r      <= gain_nxt;
      out_r       <= out_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_r;
  assign cfg_ready  = 1'b1;

`include "bezier_envelope_compressor_macros.svh"

  `BEC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken but not busy")
  `BEC_ASSERT_NOW(a_phase_bound, state_r == S_IDLE, phase_r <= PH_W'(ONE_Q24), "phase above one while idle")
  `BEC_ASSERT_NOW(a_div_only_wait, div_stat.busy, state_r == S_DIV_WAIT, "divider busy outside its wait")

endmodule
